/* design/psf_pkg.sv */
// Shared constants, operation types and the per-point multiply schedule.
package psf_pkg;

    localparam int COORD_W   = 32;
    localparam int STEPS_W   = 7;
    localparam int MAX_STEPS = 64;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd20;

    localparam int T_W    = 17;
    localparam int B_W    = 18;
    localparam int UU_W   = 34;
    localparam int A_W    = 49;
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = 80;
    localparam int HALF_W = 16;

    localparam logic [T_W-1:0]     ONE_Q16  = 17'h10000;
    localparam logic [COORD_W-1:0] SIGN_BIT = 32'h8000_0000;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_W_LAST = 5'd5;
    localparam logic [STEP_W-1:0] STEP_X0     = 5'd6;
    localparam logic [STEP_W-1:0] STEP_Y0     = 5'd14;
    localparam logic [STEP_W-1:0] STEP_OP_END = 5'd21;
    localparam logic [STEP_W-1:0] STEP_DONE   = 5'd22;

    typedef enum logic [2:0] {
        A_U, A_T, A_UU, A_TT, A_WGT
    } a_sel_t;

    typedef enum logic [2:0] {
        B_U, B_T, B_U3, B_T3, B_QLO, B_QHI
    } b_sel_t;

    typedef enum logic [1:0] {
        DST_UU, DST_TT, DST_WGT, DST_ACC
    } dst_t;

    typedef struct packed {
        logic       vld;
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        logic [1:0] idx;
        logic       coord;
        dst_t       dst;
        logic       clr;
    } psf_op_t;

    function automatic psf_op_t psf_step_op(input logic [STEP_W-1:0] step);
        psf_op_t           op;
        logic [STEP_W-1:0] k;
        op = '{vld: 1'b0, a_sel: A_U, b_sel: B_U, idx: 2'd0, coord: 1'b0,
               dst: DST_UU, clr: 1'b0};
        k  = '0;
        if (step <= STEP_W_LAST) begin
            op.vld = 1'b1;
            unique case (step[2:0])
                3'd0: begin
                    op.a_sel = A_U;  op.b_sel = B_U;  op.dst = DST_UU;
                end
                3'd1: begin
                    op.a_sel = A_T;  op.b_sel = B_T;  op.dst = DST_TT;
                end
                3'd2: begin
                    op.a_sel = A_UU; op.b_sel = B_U;  op.dst = DST_WGT; op.idx = 2'd0;
                end
                3'd3: begin
                    op.a_sel = A_UU; op.b_sel = B_T3; op.dst = DST_WGT; op.idx = 2'd1;
                end
                3'd4: begin
                    op.a_sel = A_TT; op.b_sel = B_U3; op.dst = DST_WGT; op.idx = 2'd2;
                end
                3'd5: begin
                    op.a_sel = A_TT; op.b_sel = B_T;  op.dst = DST_WGT; op.idx = 2'd3;
                end
                default: begin
                    op.vld = 1'b0;
                end
            endcase
        end else if (step <= STEP_OP_END) begin
            k        = (step < STEP_Y0) ? (step - STEP_X0) : (step - STEP_Y0);
            op.vld   = 1'b1;
            op.a_sel = A_WGT;
            op.b_sel = k[0] ? B_QHI : B_QLO;
            op.idx   = k[2:1];
            op.coord = (step >= STEP_Y0);
            op.dst   = DST_ACC;
            op.clr   = (k == '0);
        end
        return op;
    endfunction

endpackage

/* design/psf_div.sv */
// Restoring divider for 65536 / steps, one quotient bit per cycle.
module psf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [psf_pkg::STEPS_W-1:0]   divisor,
    output logic                          done,
    output logic [psf_pkg::T_W-1:0]       quo,
    output logic [psf_pkg::STEPS_W-1:0]   rem
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [psf_pkg::STEPS_W-1:0] rem_reg, rem_next;
    logic [psf_pkg::T_W-1:0]     quo_reg, quo_next;
    logic [psf_pkg::STEPS_W:0]   trial;
    logic                        fits;

    always_comb begin
        trial     = {rem_reg, (cnt_reg == 5'd0)};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? psf_pkg::STEPS_W'(trial - {1'b0, divisor})
                            : trial[psf_pkg::STEPS_W-1:0];
            quo_next = {quo_reg[psf_pkg::T_W-2:0], fits};
            if (cnt_reg == 5'(psf_pkg::T_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

/* design/psf_mac.sv */
// Shared multiplier with weight registers and the blend accumulator.
module psf_mac (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  psf_pkg::psf_op_t                       op,
    input  logic [psf_pkg::T_W-1:0]                u,
    input  logic [psf_pkg::T_W-1:0]                t,
    input  logic [3:0][psf_pkg::COORD_W-1:0]       q_x,
    input  logic [3:0][psf_pkg::COORD_W-1:0]       q_y,
    output logic [psf_pkg::COORD_W-1:0]            res_x,
    output logic [psf_pkg::COORD_W-1:0]            res_y
);

    logic [psf_pkg::UU_W-1:0]        uu_reg;
    logic [psf_pkg::UU_W-1:0]        tt_reg;
    logic [3:0][psf_pkg::A_W-1:0]    w_reg;
    logic [psf_pkg::PROD_W-1:0]      prod_reg;
    psf_pkg::psf_op_t                wb_reg;
    logic [psf_pkg::ACC_W-1:0]       acc_reg;
    logic [psf_pkg::COORD_W-1:0]     res_x_reg;

    logic [psf_pkg::A_W-1:0]         a_op;
    logic [psf_pkg::B_W-1:0]         b_op;
    logic [psf_pkg::B_W-1:0]         u3;
    logic [psf_pkg::B_W-1:0]         t3;
    logic [psf_pkg::COORD_W-1:0]     q_sel;
    logic [psf_pkg::PROD_W-1:0]      prod_next;
    logic [psf_pkg::ACC_W-1:0]       term;
    logic [psf_pkg::COORD_W-1:0]     acc_top;

    always_comb begin
        u3    = {u, 1'b0} + psf_pkg::B_W'(u);
        t3    = {t, 1'b0} + psf_pkg::B_W'(t);
        q_sel = op.coord ? q_y[op.idx] : q_x[op.idx];
        unique case (op.a_sel)
            psf_pkg::A_U:   a_op = psf_pkg::A_W'(u);
            psf_pkg::A_T:   a_op = psf_pkg::A_W'(t);
            psf_pkg::A_UU:  a_op = psf_pkg::A_W'(uu_reg);
            psf_pkg::A_TT:  a_op = psf_pkg::A_W'(tt_reg);
            psf_pkg::A_WGT: a_op = w_reg[op.idx];
            default:        a_op = '0;
        endcase
        unique case (op.b_sel)
            psf_pkg::B_U:   b_op = psf_pkg::B_W'(u);
            psf_pkg::B_T:   b_op = psf_pkg::B_W'(t);
            psf_pkg::B_U3:  b_op = u3;
            psf_pkg::B_T3:  b_op = t3;
            psf_pkg::B_QLO: b_op = psf_pkg::B_W'(q_sel[psf_pkg::HALF_W-1:0]);
            psf_pkg::B_QHI: b_op = psf_pkg::B_W'(q_sel[psf_pkg::COORD_W-1:psf_pkg::HALF_W]);
            default:        b_op = '0;
        endcase
        prod_next = psf_pkg::PROD_W'(a_op) * psf_pkg::PROD_W'(b_op);
    end

    always_comb begin
        if (wb_reg.b_sel == psf_pkg::B_QHI) begin
            term = {prod_reg[psf_pkg::ACC_W-psf_pkg::HALF_W-1:0], {psf_pkg::HALF_W{1'b0}}};
        end else begin
            term = psf_pkg::ACC_W'(prod_reg);
        end
        acc_top = acc_reg[psf_pkg::ACC_W-1:psf_pkg::ACC_W-psf_pkg::COORD_W] ^ psf_pkg::SIGN_BIT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg.vld <= 1'b0;
        end else begin
            wb_reg.vld <= op.vld;
        end
        wb_reg.a_sel <= op.a_sel;
        wb_reg.b_sel <= op.b_sel;
        wb_reg.idx   <= op.idx;
        wb_reg.coord <= op.coord;
        wb_reg.dst   <= op.dst;
        wb_reg.clr   <= op.clr;
        prod_reg     <= prod_next;
        if (wb_reg.vld) begin
            unique case (wb_reg.dst)
                psf_pkg::DST_UU:  uu_reg <= prod_reg[psf_pkg::UU_W-1:0];
                psf_pkg::DST_TT:  tt_reg <= prod_reg[psf_pkg::UU_W-1:0];
                psf_pkg::DST_WGT: w_reg[wb_reg.idx] <= prod_reg[psf_pkg::A_W-1:0];
                psf_pkg::DST_ACC: begin
                    acc_reg <= wb_reg.clr ? term : acc_reg + term;
                    if (wb_reg.clr && wb_reg.coord) begin
                        res_x_reg <= acc_top;
                    end
                end
            endcase
        end
    end

    assign res_x = res_x_reg;
    assign res_y = acc_top;

endmodule

/* design/path_segment_flattener.sv */
// Top level of the path flattener: command intake, point sequencer, output register.
// Line item: after acceptance its end point is loaded into the output register from the emit state.
// Cubic item: 65536/steps is first formed in the bit-serial divider; then each point takes
// 22 passes through the shared 49x18 multiplier, plus drain and emit.
// Ready returns once the last point is loaded; output may still be held downstream.
// Reset (aresetn low, synchronous): current point to origin, segment_steps to 20.
module path_segment_flattener (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [psf_pkg::STEPS_W-1:0]           cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    input  logic [6*psf_pkg::COORD_W-1:0]         s_axis_tdata,
    // action, new_path
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // point_x, point_y
    output logic [2*psf_pkg::COORD_W-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADV  = 5'b00100,
        ST_CALC = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    localparam int CW = psf_pkg::COORD_W;
    localparam int SW = psf_pkg::STEPS_W;

    state_t                         state_reg, state_next;
    logic [SW-1:0]                  steps_reg;
    logic [SW-1:0]                  n_reg;
    logic [SW-1:0]                  i_reg, i_next;
    logic [psf_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [psf_pkg::T_W-1:0]        t_reg, t_next;
    logic [SW-1:0]                  r_reg, r_next;
    logic [psf_pkg::T_W-1:0]        q0_reg;
    logic [SW-1:0]                  r0_reg;
    logic                           line_reg;
    logic [CW-1:0]                  cur_x_reg, cur_y_reg;
    logic [3:0][CW-1:0]             qx_reg, qy_reg;
    logic                           m_valid_reg;
    logic [CW-1:0]                  px_reg, py_reg;
    logic                           last_reg;

    logic                           accept;
    logic                           load;
    logic                           final_pt;
    logic [SW-1:0]                  n_eff;
    logic [CW-1:0]                  base_x, base_y;
    logic [SW:0]                    sum_r;
    logic                           carry;
    logic [psf_pkg::T_W-1:0]        u_val;
    logic                           div_done;
    logic [psf_pkg::T_W-1:0]        div_quo;
    logic [SW-1:0]                  div_rem;
    psf_pkg::psf_op_t               op;
    logic [CW-1:0]                  res_x, res_y;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);
    assign final_pt      = line_reg || (i_reg == n_reg);
    assign u_val         = psf_pkg::ONE_Q16 - t_reg;
    assign base_x        = s_axis_tuser[1] ? '0 : cur_x_reg;
    assign base_y        = s_axis_tuser[1] ? '0 : cur_y_reg;

    always_comb begin
        priority if (steps_reg == '0) begin
            n_eff = SW'(1);
        end else if (steps_reg > SW'(psf_pkg::MAX_STEPS)) begin
            n_eff = SW'(psf_pkg::MAX_STEPS);
        end else begin
            n_eff = steps_reg;
        end
    end

    assign op = (state_reg == ST_CALC) ? psf_pkg::psf_step_op(step_reg) : '0;

    always_comb begin
        sum_r = {1'b0, r_reg} + {1'b0, r0_reg};
        carry = (sum_r >= {1'b0, n_reg});
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        step_next  = step_reg;
        t_next     = t_reg;
        r_next     = r_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_axis_tuser[0] ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_ADV;
                    i_next     = '0;
                    t_next     = '0;
                    r_next     = '0;
                end
            end
            ST_ADV: begin
                state_next = ST_CALC;
                step_next  = '0;
                i_next     = i_reg + SW'(1);
                t_next     = t_reg + q0_reg + psf_pkg::T_W'(carry);
                r_next     = carry ? SW'(sum_r - {1'b0, n_reg}) : sum_r[SW-1:0];
            end
            ST_CALC: begin
                if (step_reg == psf_pkg::STEP_DONE) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + psf_pkg::STEP_W'(1);
                end
            end
            ST_EMIT: begin
                if (load) begin
                    state_next = final_pt ? ST_IDLE : ST_ADV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            steps_reg   <= psf_pkg::STEPS_RESET;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            step_reg    <= '0;
            t_reg       <= '0;
            r_reg       <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            step_reg  <= step_next;
            t_reg     <= t_next;
            r_reg     <= r_next;
            if (cfg_wr_en) begin
                steps_reg <= cfg_wr_data;
            end
            if (accept) begin
                cur_x_reg <= s_axis_tdata[5*CW-1:4*CW];
                cur_y_reg <= s_axis_tdata[6*CW-1:5*CW];
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            line_reg  <= !s_axis_tuser[0];
            n_reg     <= n_eff;
            qx_reg[0] <= base_x ^ psf_pkg::SIGN_BIT;
            qy_reg[0] <= base_y ^ psf_pkg::SIGN_BIT;
            qx_reg[1] <= s_axis_tdata[1*CW-1:0*CW] ^ psf_pkg::SIGN_BIT;
            qy_reg[1] <= s_axis_tdata[2*CW-1:1*CW] ^ psf_pkg::SIGN_BIT;
            qx_reg[2] <= s_axis_tdata[3*CW-1:2*CW] ^ psf_pkg::SIGN_BIT;
            qy_reg[2] <= s_axis_tdata[4*CW-1:3*CW] ^ psf_pkg::SIGN_BIT;
            qx_reg[3] <= s_axis_tdata[5*CW-1:4*CW] ^ psf_pkg::SIGN_BIT;
            qy_reg[3] <= s_axis_tdata[6*CW-1:5*CW] ^ psf_pkg::SIGN_BIT;
        end
        if (div_done) begin
            q0_reg <= div_quo;
            r0_reg <= div_rem;
        end
        if (load) begin
            px_reg   <= line_reg ? (qx_reg[3] ^ psf_pkg::SIGN_BIT) : res_x;
            py_reg   <= line_reg ? (qy_reg[3] ^ psf_pkg::SIGN_BIT) : res_y;
            last_reg <= final_pt;
        end
    end

    psf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_axis_tuser[0]),
        .divisor (n_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    psf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .u       (u_val),
        .t       (t_reg),
        .q_x     (qx_reg),
        .q_y     (qy_reg),
        .res_x   (res_x),
        .res_y   (res_y)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {py_reg, px_reg};
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (step_reg <= psf_pkg::STEP_DONE))
        else $error("point schedule step out of range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !line_reg) |-> (i_reg <= n_reg && i_reg != '0))
        else $error("point count outside 1..steps");

    a_final_t: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !line_reg && i_reg == n_reg) |-> (t_reg == psf_pkg::ONE_Q16))
        else $error("final cubic point does not reach t = 1");

    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");
`endif

endmodule

/* sim/psf_vertex_checker.sv */
`timescale 1ns / 100ps
// Vertex checker: tracks pen position and step count, predicts each vertex and compares it.
module psf_vertex_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [psf_pkg::STEPS_W-1:0]           cfg_wr_data,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [6*psf_pkg::COORD_W-1:0]         s_tdata,
    input  logic [1:0]                            s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [2*psf_pkg::COORD_W-1:0]         m_tdata,
    input  logic                                  m_tlast,
    output int                                    mismatch_count,
    output int                                    points_pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } vertex_t;

    vertex_t                      expected_vertices[$];
    logic [psf_pkg::STEPS_W-1:0]  seg_steps = psf_pkg::STEPS_RESET;
    logic [31:0]                  pen_x = '0;
    logic [31:0]                  pen_y = '0;
    int                           error_total = 0;

    // Exact cubic blend, floored after the 48-bit shift, done on sign-biased coordinates.
    function automatic logic [31:0] bezier_coord(input int t, input logic [31:0] p0,
                                                 input logic [31:0] p1, input logic [31:0] p2,
                                                 input logic [31:0] p3);
        logic [95:0] tw;
        logic [95:0] uw;
        logic [95:0] acc;
        tw  = 96'(unsigned'(t));
        uw  = psf_pkg::ONE_Q16 - tw;
        acc = uw * uw * uw * {64'b0, p0 ^ psf_pkg::SIGN_BIT}
            + 3 * uw * uw * tw * {64'b0, p1 ^ psf_pkg::SIGN_BIT}
            + 3 * uw * tw * tw * {64'b0, p2 ^ psf_pkg::SIGN_BIT}
            + tw * tw * tw * {64'b0, p3 ^ psf_pkg::SIGN_BIT};
        return acc[79:48] - psf_pkg::SIGN_BIT;
    endfunction

    function automatic void add_expected(input vertex_t v);
        expected_vertices.insert(expected_vertices.size(), v);
    endfunction

    function automatic void flatten_command(input logic cubic, input logic new_path,
                                            input logic [6*psf_pkg::COORD_W-1:0] d);
        logic [31:0] end_x;
        logic [31:0] end_y;
        int          n;
        int          t;
        end_x = d[159:128];
        end_y = d[191:160];
        if (new_path) begin
            pen_x = '0;
            pen_y = '0;
        end
        if (!cubic) begin
            add_expected(vertex_t'{end_x, end_y, 1'b1});
        end else begin
            if (seg_steps == 0) begin
                n = 1;
            end else if (seg_steps > psf_pkg::MAX_STEPS) begin
                n = psf_pkg::MAX_STEPS;
            end else begin
                n = int'(seg_steps);
            end
            for (int i = 1; i <= n; i++) begin
                t = (i * 65536) / n;
                add_expected(vertex_t'{
                    bezier_coord(t, pen_x, d[31:0], d[95:64], end_x),
                    bezier_coord(t, pen_y, d[63:32], d[127:96], end_y),
                    (i == n)});
            end
        end
        pen_x = end_x;
        pen_y = end_y;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            error_total++;
        end
    endfunction

    always @(posedge aclk) begin
        vertex_t want;
        if (!aresetn) begin
            seg_steps = psf_pkg::STEPS_RESET;
            pen_x     = '0;
            pen_y     = '0;
            expected_vertices.delete();
        end else begin
            if (cfg_wr_en) begin
                seg_steps = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (expected_vertices.size() == 0) begin
                    $error("vertex (%0d, %0d) arrived with none expected",
                           $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                    error_total++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("point_x", want.x, m_tdata[31:0]);
                    check_field("point_y", want.y, m_tdata[63:32]);
                    check_field("last", {31'b0, want.last}, {31'b0, m_tlast});
                end
            end
            if (s_tvalid && s_tready) begin
                flatten_command(s_tuser[0], s_tuser[1], s_tdata);
            end
        end
        mismatch_count <= error_total;
        points_pending <= expected_vertices.size();
    end

endmodule

/* sim/tb_path_segment_flattener.sv */
`timescale 1ns / 100ps
// Testbench top: drives path commands and step settings into the flattener and gives the verdict.
module tb_path_segment_flattener;

    localparam logic CMD_LINE    = 1'b0;
    localparam logic CMD_CUBIC   = 1'b1;
    localparam int   HOLD_CYCLES = 400;
    localparam int   STALL_LIMIT = 4000;
    localparam int   TAIL_CYCLES = 100;
    localparam int   NUM_PHASES  = 10;

    typedef struct {
        logic        action;
        logic        new_path;
        logic [31:0] c1_x;
        logic [31:0] c1_y;
        logic [31:0] c2_x;
        logic [31:0] c2_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
    } path_cmd_t;

    logic                                  aclk          = 1'b0;
    logic                                  aresetn       = 1'b0;
    logic                                  cfg_wr_en     = 1'b0;
    logic [psf_pkg::STEPS_W-1:0]           cfg_wr_data   = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [6*psf_pkg::COORD_W-1:0]         s_axis_tdata  = '0;
    logic [1:0]                            s_axis_tuser  = '0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [2*psf_pkg::COORD_W-1:0]         m_axis_tdata;
    logic                                  m_axis_tlast;

    int   mismatch_count;
    int   points_pending;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_request  = 1'b0;
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;
    int   stall_cycles  = 0;

    int   phase_steps [NUM_PHASES] = '{3, 1, 0, 5, 127, 64, 2, 10, 65, 20};
    int   phase_items [NUM_PHASES] = '{70, 45, 25, 60, 4, 4, 60, 45, 4, 50};

    path_segment_flattener i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    psf_vertex_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tlast        (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .points_pending (points_pending)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_ack) begin
            hold_ack      <= hold_request;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic path_cmd_t mk_cmd(input logic action, input logic new_path,
                                         input logic [31:0] c1_x, input logic [31:0] c1_y,
                                         input logic [31:0] c2_x, input logic [31:0] c2_y,
                                         input logic [31:0] end_x, input logic [31:0] end_y);
        path_cmd_t cmd;
        cmd.action   = action;
        cmd.new_path = new_path;
        cmd.c1_x     = c1_x;
        cmd.c1_y     = c1_y;
        cmd.c2_x     = c2_x;
        cmd.c2_y     = c2_y;
        cmd.end_x    = end_x;
        cmd.end_y    = end_y;
        return cmd;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic path_cmd_t random_cmd();
        logic action;
        action = ($urandom_range(99) < 65) ? CMD_CUBIC : CMD_LINE;
        return mk_cmd(action, $urandom_range(99) < 15, rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    task automatic send_cmd(input path_cmd_t cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cmd.end_y, cmd.end_x, cmd.c2_y, cmd.c2_x, cmd.c1_y, cmd.c1_x};
        s_axis_tuser  <= {cmd.new_path, cmd.action};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (points_pending != 0);
    endtask

    task automatic write_steps(input int steps);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= steps[psf_pkg::STEPS_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int n_sent;
        n_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(15, 51);
        @(posedge aclk);

        // default step count, line ignores its control points
        send_cmd(mk_cmd(CMD_LINE, 1'b0, '1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000));
        send_cmd(mk_cmd(CMD_CUBIC, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
        send_cmd(mk_cmd(CMD_CUBIC, 1'b1, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_cmd(mk_cmd(CMD_LINE, 1'b1, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'h0000_0001));
        send_cmd(mk_cmd(CMD_CUBIC, 1'b0, 32'h0001_8000, 32'hFFFF_0000,
                        32'h0000_0001, 32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFD_0000));
        // zero steps behaves as one
        write_steps(0);
        send_cmd(mk_cmd(CMD_CUBIC, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h0, 32'h0, 32'h1234_5678, 32'h8765_4321));
        // step count above the maximum is clamped
        write_steps(127);
        send_cmd(mk_cmd(CMD_CUBIC, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        write_steps(psf_pkg::MAX_STEPS);
        send_cmd(mk_cmd(CMD_CUBIC, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        write_steps(1);
        send_cmd(mk_cmd(CMD_CUBIC, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001,
                        32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_cmd(mk_cmd(CMD_LINE, 1'b0, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_steps(phase_steps[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (n_sent == 123) begin
                    set_idling(51, 15);
                end
                if (n_sent == 246) begin
                    set_idling(0, 0);
                end
                if (n_sent == 150) begin
                    hold_request <= ~hold_request;
                end
                if (n_sent == 300) begin
                    wait_drained();
                end
                send_cmd(random_cmd());
                n_sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && points_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
